// ----- hw/rtl/bbg_pkg.sv -----
// Shared types, constants and arithmetic helpers for the BGGR-to-gray block.
// No dependencies; compile first.
package bbg_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 10;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] psum_t;
  // 3x3 pixels, [row][col], row 0 on top
  typedef logic [2:0][2:0][PIX_W-1:0] nbh_t;

  // number of taps averaged into one color component
  typedef enum logic [1:0] {AVG1, AVG2, AVG3, AVG4} avg_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic even_r;
    logic even_c;
  } site_t;

  typedef struct packed {
    psum_t r_sum;
    avg_t  r_n;
    psum_t g_sum;
    avg_t  g_n;
    psum_t b_sum;
    avg_t  b_n;
  } taps_t;

  // floor(x/3) for x <= 767 by reciprocal multiply
  function automatic pix_t div3(input psum_t x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  function automatic psum_t s1(input pix_t a);
    return SUM_W'(a);
  endfunction

  function automatic psum_t s2(input pix_t a, input pix_t b);
    return SUM_W'(a) + SUM_W'(b);
  endfunction

  function automatic psum_t s3(input pix_t a, input pix_t b, input pix_t c);
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
  endfunction

  function automatic psum_t s4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
  endfunction

  // averages by one, two or four taps; three-tap averages go through div3
  function automatic pix_t avg_pow2(input psum_t sum, input avg_t n);
    pix_t v;
    case (n)
      AVG2:    v = sum[8:1];
      AVG4:    v = sum[9:2];
      default: v = sum[7:0];
    endcase
    return v;
  endfunction

  // pick taps for R, G and B around the center of nb
  function automatic taps_t site_taps(input nbh_t nb, input site_t s);
    taps_t t;
    pix_t  p_nw, p_n, p_ne, p_w, p_c, p_e, p_sw, p_s, p_se;
    p_nw = nb[0][0]; p_n = nb[0][1]; p_ne = nb[0][2];
    p_w  = nb[1][0]; p_c = nb[1][1]; p_e  = nb[1][2];
    p_sw = nb[2][0]; p_s = nb[2][1]; p_se = nb[2][2];
    t = '{r_sum: s1(p_c), r_n: AVG1, g_sum: s1(p_c), g_n: AVG1,
          b_sum: s1(p_c), b_n: AVG1};
    if (s.top) begin
      if (s.left) begin
        t.r_sum = s1(p_se);          t.r_n = AVG1;
        t.g_sum = s2(p_e, p_s);      t.g_n = AVG2;
        t.b_sum = s1(p_c);           t.b_n = AVG1;
      end else if (s.right) begin
        t.r_sum = s1(p_s);           t.r_n = AVG1;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s1(p_w);           t.b_n = AVG1;
      end else if (s.even_c) begin
        t.r_sum = s2(p_sw, p_se);    t.r_n = AVG2;
        t.g_sum = s3(p_w, p_e, p_s); t.g_n = AVG3;
        t.b_sum = s1(p_c);           t.b_n = AVG1;
      end else begin
        t.r_sum = s1(p_s);           t.r_n = AVG1;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s2(p_w, p_e);      t.b_n = AVG2;
      end
    end else if (s.bot) begin
      if (s.left) begin
        t.r_sum = s1(p_e);           t.r_n = AVG1;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s1(p_n);           t.b_n = AVG1;
      end else if (s.right) begin
        t.r_sum = s1(p_c);           t.r_n = AVG1;
        t.g_sum = s2(p_w, p_n);      t.g_n = AVG2;
        t.b_sum = s1(p_nw);          t.b_n = AVG1;
      end else if (s.even_c) begin
        t.r_sum = s2(p_w, p_e);      t.r_n = AVG2;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s1(p_n);           t.b_n = AVG1;
      end else begin
        t.r_sum = s1(p_c);           t.r_n = AVG1;
        t.g_sum = s3(p_w, p_e, p_n); t.g_n = AVG3;
        t.b_sum = s2(p_nw, p_ne);    t.b_n = AVG2;
      end
    end else if (s.left) begin
      if (s.even_r) begin
        t.r_sum = s2(p_ne, p_se);    t.r_n = AVG2;
        t.g_sum = s3(p_n, p_s, p_e); t.g_n = AVG3;
        t.b_sum = s1(p_c);           t.b_n = AVG1;
      end else begin
        t.r_sum = s1(p_e);           t.r_n = AVG1;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s2(p_n, p_s);      t.b_n = AVG2;
      end
    end else if (s.right) begin
      if (s.even_r) begin
        t.r_sum = s1(p_n);           t.r_n = AVG1;
        t.g_sum = s1(p_c);           t.g_n = AVG1;
        t.b_sum = s1(p_w);           t.b_n = AVG1;
      end else begin
        t.r_sum = s1(p_c);           t.r_n = AVG1;
        t.g_sum = s3(p_w, p_n, p_s); t.g_n = AVG3;
        t.b_sum = s2(p_nw, p_sw);    t.b_n = AVG2;
      end
    end else if (s.even_r) begin
      if (!s.even_c) begin
        t.r_sum = s2(p_n, p_s);                t.r_n = AVG2;
        t.g_sum = s1(p_c);                     t.g_n = AVG1;
        t.b_sum = s2(p_w, p_e);                t.b_n = AVG2;
      end else begin
        t.r_sum = s4(p_nw, p_ne, p_sw, p_se);  t.r_n = AVG4;
        t.g_sum = s4(p_n, p_s, p_w, p_e);      t.g_n = AVG4;
        t.b_sum = s1(p_c);                     t.b_n = AVG1;
      end
    end else if (!s.even_c) begin
      t.r_sum = s1(p_c);                       t.r_n = AVG1;
      t.g_sum = s4(p_n, p_s, p_w, p_e);        t.g_n = AVG4;
      t.b_sum = s4(p_nw, p_ne, p_sw, p_se);    t.b_n = AVG4;
    end else begin
      t.r_sum = s2(p_w, p_e);                  t.r_n = AVG2;
      t.g_sum = s1(p_c);                       t.g_n = AVG1;
      t.b_sum = s2(p_n, p_s);                  t.b_n = AVG2;
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/bbg_in_if.sv -----
// Pixel input channel: valid/ready plus one Bayer sample.
// Depends on bbg_pkg.
interface bbg_in_if;
  import bbg_pkg::*;

  logic valid;
  logic ready;
  pix_t bayer_pixel;

  modport source (output valid, output bayer_pixel, input ready);
  modport sink   (input valid, input bayer_pixel, output ready);
endinterface

// ----- hw/rtl/bbg_out_if.sv -----
// Result channel: valid/ready plus gray level, position and end markers.
// Depends on bbg_pkg.
interface bbg_out_if #(
  parameter int ROW_W = $clog2(bbg_pkg::MAX_HEIGHT_DEF),
  parameter int COL_W = $clog2(bbg_pkg::MAX_WIDTH_DEF)
);
  import bbg_pkg::*;

  logic             valid;
  logic             ready;
  pix_t             gray_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             run_last;
  logic             frame_last;

  modport source (output valid, output gray_value, output out_row, output out_col,
                  output run_last, output frame_last, input ready);
  modport sink   (input valid, input gray_value, input out_row, input out_col,
                  input run_last, input frame_last, output ready);
endinterface

// ----- hw/rtl/bbg_cfg_if.sv -----
// Register write channel: valid/ready plus register index and write data.
// Depends on bbg_pkg.
interface bbg_cfg_if;
  import bbg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- hw/rtl/bbg_line_store.sv -----
// Two line memories (rows r-2 and r-1), one write and one registered read port each.
// Depends on bbg_pkg.
module bbg_line_store #(
  parameter int  DEPTH  = bbg_pkg::MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  bbg_pkg::pix_t     wr_older,
  input  bbg_pkg::pix_t     wr_newer,
  output bbg_pkg::pix_t     rd_older,
  output bbg_pkg::pix_t     rd_newer
);
  import bbg_pkg::*;

  pix_t older_mem [DEPTH];
  pix_t newer_mem [DEPTH];
  pix_t rd_older_r;
  pix_t rd_newer_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older_r <= older_mem[rd_addr];
      rd_newer_r <= newer_mem[rd_addr];
    end
  end

  assign rd_older = rd_older_r;
  assign rd_newer = rd_newer_r;

endmodule

// ----- hw/rtl/bayer_bggr_to_gray.sv -----
// Top level: streaming bilinear BGGR demosaic to grayscale.
// Depends on bbg_pkg, bbg_in_if, bbg_out_if, bbg_cfg_if and bbg_line_store.
//
//  channel   | dir | payload                                        | transfer
//  ----------+-----+------------------------------------------------+------------------
//  in_chan   | in  | bayer_pixel[7:0]                               | valid & ready
//  out_chan  | out | gray_value, out_row, out_col, run_last,        | valid & ready
//            |     | frame_last                                     |
//  cfg_chan  | in  | reg_index (0 frame_width, 1 frame_height),     | valid & ready
//            |     | reg_data                                       | (ready always 1)
//
// Throughput: one pixel per cycle while each pixel yields at most one result and
// out_chan does not stall. The last column of a row below the top yields two
// results, every bottom-row pixel past column 0 two (four on the last pixel of
// a frame); the single result path emits one per cycle, so such a pixel holds
// the emitter until all its results are sent. A result passes the line read,
// window/emit, color and gray stages into the output register after the pixel
// transfer that causes it. Reset (rst_n, synchronous) clears the counters, the
// window and all valids and loads 640 x 480; the line memories have no clearing
// pass, since entries read before they are written within a frame feed no result.
// Stalls propagate back through the output, color, emit and line read stages to
// in_chan; a pixel transfer with an invalid geometry is taken and dropped.
module bayer_bggr_to_gray #(
  parameter int MAX_WIDTH  = bbg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbg_pkg::MAX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bbg_in_if.sink    in_chan,
  bbg_out_if.source out_chan,
  bbg_cfg_if.sink   cfg_chan
);
  import bbg_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // configuration and position counters
  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             geom_ok;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             cur_col_last;
  logic             cur_row_last;
  logic             cfg_fire;
  logic             in_fire;
  logic             take;

  // line read stage
  logic             a_vld_r;
  pix_t             a_pix_r;
  logic [ROW_W-1:0] a_row_r;
  logic [COL_W-1:0] a_col_r;
  logic             a_col_last_r;
  logic             a_row_last_r;
  logic [3:0]       a_mask;
  logic             a_adv;
  pix_t             rd_older;
  pix_t             rd_newer;

  // window and emitter
  nbh_t             win_r;
  logic             e_vld_r;
  logic [3:0]       e_mask_r;
  logic [ROW_W-1:0] e_row_r;
  logic [COL_W-1:0] e_col_r;
  logic             e_top_r;
  logic             e_left_r;
  logic [1:0]       slot;
  logic [3:0]       slot_hot;
  logic [3:0]       e_rest;
  logic             e_free;
  logic             e_emit;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  site_t            site;
  nbh_t             nb;
  taps_t            taps;
  pix_t             red_v, grn_v, blu_v;

  // color stage
  logic             c_vld_r;
  pix_t             c_red_r, c_grn_r, c_blu_r;
  logic [ROW_W-1:0] c_row_r;
  logic [COL_W-1:0] c_col_r;
  logic             c_run_last_r;
  logic             c_frame_last_r;
  logic             c_take;

  // output register
  logic             o_vld_r;
  pix_t             o_gray_r;
  logic [ROW_W-1:0] o_row_r;
  logic [COL_W-1:0] o_col_r;
  logic             o_run_last_r;
  logic             o_frame_last_r;
  logic             o_take;

  // ---------------------------------------------------------------------------
  // Handshake chain: output -> color -> emitter -> line read -> input
  // ---------------------------------------------------------------------------
  assign o_take  = !o_vld_r || out_chan.ready;
  assign c_take  = !c_vld_r || o_take;
  assign e_emit  = e_vld_r && c_take;
  assign e_free  = !e_vld_r || (c_take && (e_rest == 4'b0000));
  assign a_adv   = a_vld_r && e_free;

  assign in_chan.ready  = !a_vld_r || a_adv;
  assign cfg_chan.ready = 1'b1;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign take     = in_fire && geom_ok;

  // ---------------------------------------------------------------------------
  // Geometry check and counters
  // ---------------------------------------------------------------------------
  assign geom_ok = !frame_width_r[0] && !frame_height_r[0]
                && (frame_width_r >= FW_W'(2)) && (frame_height_r >= FH_W'(2))
                && (32'(frame_width_r) <= 32'(MAX_WIDTH))
                && (32'(frame_height_r) <= 32'(MAX_HEIGHT));

  always_comb begin
    cur_row = row_r;
    cur_col = col_r;
    // restart the frame if a counter sits outside the current geometry
    if ((32'(row_r) >= 32'(frame_height_r)) || (32'(col_r) >= 32'(frame_width_r))) begin
      cur_row = '0;
      cur_col = '0;
    end
    cur_col_last = (32'(cur_col) == (32'(frame_width_r) - 32'd1));
    cur_row_last = (32'(cur_row) == (32'(frame_height_r) - 32'd1));
    if (cur_col_last) begin
      col_nxt = '0;
      row_nxt = cur_row_last ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_nxt = cur_col + COL_W'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      row_r          <= '0;
      col_r          <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_chan.reg_index)
        REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_chan.reg_data[FW_W-1:0];
          row_r         <= '0;
          col_r         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_chan.reg_data[FH_W-1:0];
          row_r          <= '0;
          col_r          <= '0;
        end
        default: begin
          // index beyond the register list: drop the write
        end
      endcase
    end else if (take) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read column at the pixel transfer, write back when the pixel
  // moves into the window. The same column is touched again only a full row
  // later, so reads and writes never race.
  // ---------------------------------------------------------------------------
  bbg_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk      (clk),
    .rd_en    (take),
    .rd_addr  (cur_col),
    .wr_en    (a_adv),
    .wr_addr  (a_col_r),
    .wr_older (rd_newer),
    .wr_newer (a_pix_r),
    .rd_older (rd_older),
    .rd_newer (rd_newer)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (take) begin
      a_vld_r <= 1'b1;
    end else if (a_adv) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_pix_r      <= in_chan.bayer_pixel;
      a_row_r      <= cur_row;
      a_col_r      <= cur_col;
      a_col_last_r <= cur_col_last;
      a_row_last_r <= cur_row_last;
    end
  end

  // Results caused by this pixel, in emission order:
  // bit 0 (r-1,c-1), bit 1 (r-1,W-1), bit 2 (H-1,c-1), bit 3 (H-1,W-1).
  always_comb begin
    a_mask[0] = (a_row_r != '0) && (a_col_r != '0);
    a_mask[1] = a_mask[0] && a_col_last_r;
    a_mask[2] = a_row_last_r && (a_col_r != '0);
    a_mask[3] = a_mask[2] && a_col_last_r;
  end

  // ---------------------------------------------------------------------------
  // Window: shift left and load the new column when the emitter takes a pixel
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= rd_older;
      win_r[1][2] <= rd_newer;
      win_r[2][2] <= a_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Emitter: one result per cycle while the color stage takes it, lowest pending slot first
  // ---------------------------------------------------------------------------
  always_comb begin
    if (e_mask_r[0]) begin
      slot = 2'd0;
    end else if (e_mask_r[1]) begin
      slot = 2'd1;
    end else if (e_mask_r[2]) begin
      slot = 2'd2;
    end else begin
      slot = 2'd3;
    end
    slot_hot = 4'b0001 << slot;
    e_rest   = e_mask_r & ~slot_hot;
  end

  // slot bit 1 picks the bottom row, bit 0 the last column
  assign sel_row = slot[1] ? e_row_r : e_row_r - ROW_W'(1);
  assign sel_col = slot[0] ? e_col_r : e_col_r - COL_W'(1);

  always_comb begin
    site.top    = !slot[1] && e_top_r;
    site.bot    = slot[1];
    site.left   = !slot[0] && e_left_r;
    site.right  = slot[0];
    site.even_r = !sel_row[0];
    site.even_c = !sel_col[0];
  end

  // neighborhood centered on the selected window cell, zero outside
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i + int'(slot[1]) < 3) && (j + int'(slot[0]) < 3)) begin
          nb[i][j] = win_r[2'(i + int'(slot[1]))][2'(j + int'(slot[0]))];
        end else begin
          nb[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    taps  = site_taps(nb, site);
    red_v = avg_pow2(taps.r_sum, taps.r_n);
    blu_v = avg_pow2(taps.b_sum, taps.b_n);
    grn_v = (taps.g_n == AVG3) ? div3(taps.g_sum) : avg_pow2(taps.g_sum, taps.g_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r  <= 1'b0;
      e_mask_r <= '0;
    end else if (a_adv) begin
      e_vld_r  <= (a_mask != 4'b0000);
      e_mask_r <= a_mask;
    end else if (e_emit) begin
      e_mask_r <= e_rest;
      if (e_rest == 4'b0000) begin
        e_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      e_row_r  <= a_row_r;
      e_col_r  <= a_col_r;
      e_top_r  <= (a_row_r == ROW_W'(1));
      e_left_r <= (a_col_r == COL_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Color stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_take) begin
      c_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_emit) begin
      c_red_r        <= red_v;
      c_grn_r        <= grn_v;
      c_blu_r        <= blu_v;
      c_row_r        <= sel_row;
      c_col_r        <= sel_col;
      c_run_last_r   <= (e_rest == 4'b0000);
      c_frame_last_r <= (slot == 2'd3);
    end
  end

  // ---------------------------------------------------------------------------
  // Gray stage and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_take) begin
      o_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_take && c_vld_r) begin
      o_gray_r       <= div3(SUM_W'(c_red_r) + SUM_W'(c_grn_r) + SUM_W'(c_blu_r));
      o_row_r        <= c_row_r;
      o_col_r        <= c_col_r;
      o_run_last_r   <= c_run_last_r;
      o_frame_last_r <= c_frame_last_r;
    end
  end

  assign out_chan.valid      = o_vld_r;
  assign out_chan.gray_value = o_gray_r;
  assign out_chan.out_row    = o_row_r;
  assign out_chan.out_col    = o_col_r;
  assign out_chan.run_last   = o_run_last_r;
  assign out_chan.frame_last = o_frame_last_r;

endmodule
